FILE: sv/permutation_rank_visited_set_unit_defines.svh
// Assertion macros for the permutation rank visited set unit.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef PERMUTATION_RANK_VISITED_SET_UNIT_DEFINES_SVH
`define PERMUTATION_RANK_VISITED_SET_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PRVS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PRVS_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PRVS_ASSERT(lbl, clk, rstn, prop, msg)
`define PRVS_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

FILE: sv/prvs_pkg.sv
// Package for the permutation rank visited set unit: item types, command codes,
// factorial table and controller/datapath signal groups. No dependencies.
`default_nettype none
package prvs_pkg;

  localparam int MAX_ELEMS     = 8;
  localparam int NUM_ELEMS_DEF = 8;
  localparam int ELEM_W        = 4;
  localparam int RANK_W        = 16;
  localparam int ROW_BITS      = 32;
  localparam int BIT_W         = $clog2(ROW_BITS);

  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_RANK  = 1'b1;

  localparam logic [RANK_W-1:0] FACT [MAX_ELEMS] = '{
    16'd1, 16'd1, 16'd2, 16'd6, 16'd24, 16'd120, 16'd720, 16'd5040
  };

  typedef struct packed {
    logic              cmd;
    logic [ELEM_W-1:0] elem_0;
    logic [ELEM_W-1:0] elem_1;
    logic [ELEM_W-1:0] elem_2;
    logic [ELEM_W-1:0] elem_3;
    logic [ELEM_W-1:0] elem_4;
    logic [ELEM_W-1:0] elem_5;
    logic [ELEM_W-1:0] elem_6;
    logic [ELEM_W-1:0] elem_7;
  } in_item_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              first_visit;
    logic              invalid;
  } out_item_t;

  typedef struct packed {
    logic cap;
    logic sum_en;
    logic fin;
    logic sweep;
    logic clr_resp;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic sweep_last;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: sv/prvs_stream_if.sv
// Valid/ready stream interface carrying one item of payload_t per handshake.
// Payload type is supplied at instantiation, typically from prvs_pkg.
`default_nettype none
interface prvs_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: sv/prvs_map.sv
// Visited bitmap store: MAP_ROWS rows of prvs_pkg::ROW_BITS bits,
// one write port and one registered read port. Depends on prvs_pkg.
`default_nettype none
module prvs_map #(
  parameter int MAP_ROWS = 1260,
  localparam int AW = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rd_en_i,
  input  wire logic [AW-1:0]                 rd_addr_i,
  output logic      [prvs_pkg::ROW_BITS-1:0] rd_data_o,
  input  wire logic                          wr_en_i,
  input  wire logic [AW-1:0]                 wr_addr_i,
  input  wire logic [prvs_pkg::ROW_BITS-1:0] wr_data_i
);

  logic [prvs_pkg::ROW_BITS-1:0] mem [MAP_ROWS];
  logic [prvs_pkg::ROW_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

FILE: sv/prvs_dp.sv
// Datapath: validity check, Lehmer digits times factorials, rank sum,
// bitmap row update, sweep counter and output register. Depends on prvs_pkg and the assertion macro header.
`default_nettype none
`include "permutation_rank_visited_set_unit_defines.svh"
module prvs_dp #(
  parameter int NUM_ELEMS = prvs_pkg::NUM_ELEMS_DEF,
  parameter int MAP_ROWS  = 1260,
  localparam int AW = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire prvs_pkg::ctrl_cmd_t           cmd_i,
  output prvs_pkg::dp_stat_t                 stat_o,
  input  wire prvs_pkg::in_item_t            in_item_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output prvs_pkg::out_item_t                out_item_o,
  output logic                               rd_en_o,
  output logic      [AW-1:0]                 rd_addr_o,
  input  wire logic [prvs_pkg::ROW_BITS-1:0] rd_data_i,
  output logic                               wr_en_o,
  output logic      [AW-1:0]                 wr_addr_o,
  output logic      [prvs_pkg::ROW_BITS-1:0] wr_data_o
);

  localparam int ME = prvs_pkg::MAX_ELEMS;
  localparam int RW = prvs_pkg::RANK_W;
  localparam logic [ME-1:0] FULL = ME'((1 << NUM_ELEMS) - 1);

  logic [prvs_pkg::ELEM_W-1:0] elem [ME];
  logic [RW-1:0]               term_d [ME];
  logic [RW-1:0]               term_q [ME];
  logic                        vld_d, vld_q;
  logic [RW-1:0]               rank_sum;
  logic [RW-1:0]               rank_q;
  logic                        vld_s_q;
  logic [AW-1:0]               cnt_q;
  logic                        out_valid_q;
  prvs_pkg::out_item_t         out_item_q;
  prvs_pkg::out_item_t         res;
  logic                        bit_hit;
  logic                        out_free;
  logic                        sweep_last;
  logic [prvs_pkg::BIT_W-1:0]  bit_idx;

  assign elem[0] = in_item_i.elem_0;
  assign elem[1] = in_item_i.elem_1;
  assign elem[2] = in_item_i.elem_2;
  assign elem[3] = in_item_i.elem_3;
  assign elem[4] = in_item_i.elem_4;
  assign elem[5] = in_item_i.elem_5;
  assign elem[6] = in_item_i.elem_6;
  assign elem[7] = in_item_i.elem_7;

  always_comb begin
    logic [ME-1:0] seen;
    logic          rng_ok;
    logic [2:0]    cnt;
    logic [2:0]    digit;
    logic [2:0]    widx;
    seen   = '0;
    rng_ok = 1'b1;
    for (int i = 0; i < ME; i++) begin
      cnt  = '0;
      widx = 3'(NUM_ELEMS - 1 - i);
      for (int j = 0; j < i; j++) begin
        cnt = cnt + 3'(elem[j] < elem[i]);
      end
      digit = 3'(elem[i] - 4'd1) - cnt;
      if (i < NUM_ELEMS) begin
        if (elem[i] == '0 || elem[i] > 4'(NUM_ELEMS)) begin
          rng_ok = 1'b0;
        end
        seen      = seen | (ME'(1) << 3'(elem[i] - 4'd1));
        term_d[i] = RW'(digit * prvs_pkg::FACT[widx]);
      end else begin
        term_d[i] = '0;
      end
    end
    vld_d = rng_ok && (seen == FULL);
  end

  always_comb begin
    rank_sum = '0;
    for (int i = 0; i < ME; i++) begin
      rank_sum = rank_sum + term_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      term_q <= term_d;
      vld_q  <= vld_d;
    end
    if (cmd_i.sum_en) begin
      rank_q  <= rank_sum;
      vld_s_q <= vld_q;
    end
  end

  assign rd_en_o   = cmd_i.sum_en && vld_q;
  assign rd_addr_o = AW'(rank_sum >> prvs_pkg::BIT_W);

  assign bit_idx = rank_q[prvs_pkg::BIT_W-1:0];
  assign bit_hit = rd_data_i[bit_idx];

  always_comb begin
    if (cmd_i.sweep) begin
      wr_en_o   = 1'b1;
      wr_addr_o = cnt_q;
      wr_data_o = '0;
    end else begin
      wr_en_o   = cmd_i.fin && vld_s_q && !bit_hit;
      wr_addr_o = AW'(rank_q >> prvs_pkg::BIT_W);
      wr_data_o = rd_data_i | (prvs_pkg::ROW_BITS'(1) << bit_idx);
    end
  end

  assign sweep_last = (cnt_q == AW'(MAP_ROWS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.sweep) begin
      cnt_q <= sweep_last ? '0 : cnt_q + AW'(1);
    end
  end

  always_comb begin
    res = '0;
    if (cmd_i.fin) begin
      res.rank        = vld_s_q ? rank_q : '0;
      res.first_visit = vld_s_q && !bit_hit;
      res.invalid     = !vld_s_q;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin || cmd_i.clr_resp) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin || cmd_i.clr_resp) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_item_q;
  assign stat_o.out_free   = out_free;
  assign stat_o.sweep_last = sweep_last;

  `PRVS_ASSERT(a_mark_sets_first, clk_i, rst_ni, (cmd_i.fin && vld_s_q && !bit_hit) |=> (out_valid_q && out_item_q.first_visit), "fresh rank not reported as first visit")
  `PRVS_ASSERT_NORST(a_invalid_zero, clk_i, (out_valid_q && out_item_q.invalid) |-> (out_item_q.rank == '0 && !out_item_q.first_visit), "invalid item carries rank or visit flag")

endmodule
`default_nettype wire

FILE: sv/prvs_ctrl.sv
// Controller: sequences capture, rank sum, bitmap read-modify-write and
// clearing sweeps. Depends on prvs_pkg and the assertion macro header.
`default_nettype none
`include "permutation_rank_visited_set_unit_defines.svh"
module prvs_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_cmd_i,
  output logic                     in_ready_o,
  input  wire prvs_pkg::dp_stat_t  stat_i,
  output prvs_pkg::ctrl_cmd_t      cmd_o
);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SUM   = 3'd2;
  localparam logic [2:0] ST_MARK  = 3'd3;
  localparam logic [2:0] ST_CLEAR = 3'd4;
  localparam logic [2:0] ST_CRESP = 3'd5;

  logic [2:0] state_d, state_q;
  logic       in_ready;
  logic       accept;

  assign in_ready = (state_q == ST_IDLE) || (state_q == ST_MARK && stat_i.out_free);
  assign accept   = in_valid_i && in_ready;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd_i == prvs_pkg::CMD_RANK) begin
            cmd_o.cap = 1'b1;
            state_d   = ST_SUM;
          end else begin
            state_d = ST_CLEAR;
          end
        end
      end
      ST_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d      = ST_MARK;
      end
      ST_MARK: begin
        if (stat_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_IDLE;
          if (accept) begin
            if (in_cmd_i == prvs_pkg::CMD_RANK) begin
              cmd_o.cap = 1'b1;
              state_d   = ST_SUM;
            end else begin
              state_d = ST_CLEAR;
            end
          end
        end
      end
      ST_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.sweep_last) state_d = ST_CRESP;
      end
      ST_CRESP: begin
        if (stat_i.out_free) begin
          cmd_o.clr_resp = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = in_ready;

  `PRVS_ASSERT(a_fin_slot_free, clk_i, rst_ni, (cmd_o.fin || cmd_o.clr_resp) |-> stat_i.out_free, "result loaded into occupied output register")
  `PRVS_ASSERT(a_sum_to_mark, clk_i, rst_ni, (state_q == ST_SUM) |=> (state_q == ST_MARK), "rank sum not followed by bitmap update")

endmodule
`default_nettype wire

FILE: sv/permutation_rank_visited_set_unit.sv
// A rank item is captured on acceptance, then summed into the rank register as its
// bitmap row is read; once the output register is free, the row is written back,
// the result loaded and a new rank item may be accepted. A clear sweeps all
// MAP_ROWS rows (1260 for 8 elements) to zero, then loads its result. Reset is
// asynchronous, active low; after it the bitmap is swept clear, ready low.
// Top level; depends on prvs_pkg, prvs_stream_if, prvs_ctrl, prvs_dp and prvs_map.
`default_nettype none
module permutation_rank_visited_set_unit #(
  parameter int NUM_ELEMS = prvs_pkg::NUM_ELEMS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  prvs_stream_if.sink   in_i,
  prvs_stream_if.source out_o
);

  localparam int MAP_BITS = int'(prvs_pkg::FACT[NUM_ELEMS-1]) * NUM_ELEMS;
  localparam int MAP_ROWS = (MAP_BITS + prvs_pkg::ROW_BITS - 1) / prvs_pkg::ROW_BITS;
  localparam int AW       = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;

  prvs_pkg::ctrl_cmd_t           cmd;
  prvs_pkg::dp_stat_t            stat;
  prvs_pkg::in_item_t            in_item;
  prvs_pkg::out_item_t           out_item;
  logic                          out_valid;
  logic                          rd_en, wr_en;
  logic [AW-1:0]                 rd_addr, wr_addr;
  logic [prvs_pkg::ROW_BITS-1:0] rd_data, wr_data;

  assign in_item = in_i.payload;

  prvs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_item.cmd),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  prvs_dp #(
    .NUM_ELEMS (NUM_ELEMS),
    .MAP_ROWS  (MAP_ROWS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_item_i   (in_item),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_item_o  (out_item),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  prvs_map #(
    .MAP_ROWS (MAP_ROWS)
  ) u_map (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  assign out_o.valid   = out_valid;
  assign out_o.payload = out_item;

endmodule
`default_nettype wire
